[rtl/l3dti_pkg.sv]
// shared types, constants and address helper for the 3d lut trilinear unit
// no dependencies; imported by every module of the block except l3dti_ram
`timescale 1ns / 1ps
package l3dti_pkg;

  localparam int NUM_TYPES   = 4;
  localparam int NUM_NODES   = 216;
  localparam int NUM_BANKS   = 8;
  localparam int NUM_CH      = 3;
  localparam int BANK_NODES  = 27;
  localparam int BANK_DEPTH  = NUM_TYPES * BANK_NODES;
  localparam int BANK_AW     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int STEP        = 51;
  localparam int DIV_TOTAL   = STEP * STEP * STEP;
  // floor(2^32 / 51^3), quotient estimate is low by at most one
  localparam int RECIP_51C   = 32377;
  // ceil(2^18 / 51), exact floor division for 8-bit values
  localparam int RECIP_51    = 5141;
  localparam int QUEUE_DEPTH = 4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [1:0] transform_type;
    logic [7:0] grid_node;
    logic [1:0] grid_channel;
    logic [7:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } out_item_t;

  // decoded item between front and back
  typedef struct packed {
    logic            op;
    logic [1:0]      ttype;
    logic            type_ok;
    logic            wr_ok;
    logic [2:0][2:0] idx;   // lower cell index per axis, or node coordinate on a write
    logic [2:0][5:0] rem;
    logic [1:0]      chan;
    logic [7:0]      value;
  } q_item_t;

  function automatic logic [BANK_AW-1:0] bank_addr(input logic [1:0] t, input logic [2:0] ir,
                                                   input logic [2:0] ig, input logic [2:0] ib);
    logic [9:0] a;
    a = 10'(t) * 10'd27 + 10'(ir[2:1]) * 10'd9 + 10'(ig[2:1]) * 10'd3 + 10'(ib[2:1]);
    return BANK_AW'(a);
  endfunction

endpackage

[rtl/l3dti_ram.sv]
// generic single write port, single registered read port ram
// no dependencies
`timescale 1ns / 1ps
module l3dti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 108,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/l3dti_front.sv]
// front: accepts items, splits channels by 51, decodes write node coordinates
// depends on l3dti_pkg
`timescale 1ns / 1ps
module l3dti_front import l3dti_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     push,
  output q_item_t  push_item,
  input  logic     q_full
);

  logic    f_valid;
  q_item_t f_item;
  q_item_t dec;

  always_comb begin
    logic [7:0]  c [3];
    logic [20:0] p;
    logic [2:0]  lo;
    logic [8:0]  q36;
    logic [5:0]  t;
    logic [11:0] q6;
    logic [2:0]  nr;
    logic [2:0]  ng;
    logic [2:0]  nb;
    c[0] = in_data.red_in;
    c[1] = in_data.green_in;
    c[2] = in_data.blue_in;
    p   = '0;
    lo  = '0;
    q36 = '0;
    t   = '0;
    q6  = '0;
    nr  = '0;
    ng  = '0;
    nb  = '0;
    dec = '0;
    dec.op      = in_data.op;
    dec.ttype   = in_data.transform_type;
    dec.type_ok = int'(in_data.transform_type) < NUM_TYPES;
    dec.chan    = in_data.grid_channel;
    dec.value   = in_data.entry_value;
    if (in_data.op == OP_PIXEL) begin
      for (int k = 0; k < 3; k++) begin
        p = 21'(c[k]) * 21'(RECIP_51);
        lo = p[20:18];
        dec.idx[k] = lo;
        dec.rem[k] = 6'(c[k] - 8'(lo) * 8'd51);
      end
    end else begin
      // node = (r*6+g)*6+b
      q36 = 9'((14'(in_data.grid_node) * 14'd57) >> 11);
      nr  = q36[2:0];
      t   = 6'(in_data.grid_node - 8'(nr) * 8'd36);
      q6  = 12'(t) * 12'd43;
      ng  = q6[10:8];
      nb  = 3'(t - 6'(ng) * 6'd6);
      dec.idx[0] = nr;
      dec.idx[1] = ng;
      dec.idx[2] = nb;
    end
    dec.wr_ok = dec.type_ok && (int'(in_data.grid_node) < NUM_NODES)
                && (int'(in_data.grid_channel) < NUM_CH);
  end

  assign in_ready  = !f_valid || !q_full;
  assign push      = f_valid && !q_full;
  assign push_item = f_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= (f_valid && !push) || (in_valid && in_ready);
    end
    if (in_valid && in_ready) begin
      f_item <= dec;
    end
  end

endmodule

[rtl/l3dti_queue.sv]
// short fifo of decoded items between front and back
// depends on l3dti_pkg
`timescale 1ns / 1ps
module l3dti_queue import l3dti_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output q_item_t head
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  q_item_t         slots [QUEUE_DEPTH];
  logic [PW-1:0]   rd_ptr;
  logic [PW-1:0]   wr_ptr;
  logic [PW:0]     count;

  assign full       = count == (PW+1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

[rtl/l3dti_back.sv]
// back: banked grid store, corner weights, weighted sums, divide by 51^3
// depends on l3dti_pkg and l3dti_ram
`timescale 1ns / 1ps
module l3dti_back import l3dti_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  q_item_t   head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic adv;
  logic is_pix;

  logic [BANK_AW-1:0] raddr [NUM_BANKS];
  logic [11:0]        rg_next [NUM_BANKS];
  logic [5:0]         wb_next [NUM_BANKS];
  logic [BANK_AW-1:0] waddr;
  logic [2:0]         wbank;
  logic               we;
  logic               re;
  logic [7:0]         rdata [NUM_BANKS][NUM_CH];

  logic        v1, z1, v2, z2, v3, z3, v4, z4, v5, z5;
  logic [11:0] rg1 [NUM_BANKS];
  logic [5:0]  wb1 [NUM_BANKS];
  logic [17:0] w2  [NUM_BANKS];
  logic [7:0]  d2  [NUM_BANKS][NUM_CH];
  logic [25:0] p3  [NUM_BANKS][NUM_CH];
  logic [25:0] s4  [NUM_CH];
  logic [25:0] s5  [NUM_CH];
  logic [7:0]  q5  [NUM_CH];

  assign adv    = !out_valid || out_ready;
  assign pop    = head_valid && adv;
  assign is_pix = head.op == OP_PIXEL;
  assign re     = pop && is_pix && head.type_ok;
  assign we     = pop && !is_pix && head.wr_ok;
  assign waddr  = bank_addr(head.ttype, head.idx[0], head.idx[1], head.idx[2]);
  assign wbank  = {head.idx[0][0], head.idx[1][0], head.idx[2][0]};

  // per bank: pick lower or upper index on each axis by parity
  always_comb begin
    logic       use_hi;
    logic [2:0] hi_idx;
    logic [2:0] sel [3];
    logic [5:0] aw  [3];
    for (int b = 0; b < NUM_BANKS; b++) begin
      for (int k = 0; k < 3; k++) begin
        use_hi = head.idx[k][0] != b[2-k];
        hi_idx = (head.idx[k] == 3'd5) ? 3'd4 : head.idx[k] + 3'd1;
        sel[k] = use_hi ? hi_idx : head.idx[k];
        aw[k]  = use_hi ? head.rem[k] : 6'd51 - head.rem[k];
      end
      raddr[b]   = bank_addr(head.ttype, sel[0], sel[1], sel[2]);
      rg_next[b] = 12'(aw[0]) * 12'(aw[1]);
      wb_next[b] = aw[2];
    end
  end

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
      l3dti_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_ram (
        .clk   (clk),
        .we    (we && wbank == 3'(b) && head.chan == 2'(ch)),
        .waddr (waddr),
        .wdata (head.value),
        .re    (re),
        .raddr (raddr[b]),
        .rdata (rdata[b][ch])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= pop && is_pix;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      out_valid <= v5;
    end
    if (adv) begin
      z1 <= !head.type_ok;
      z2 <= z1;
      z3 <= z2;
      z4 <= z3;
      z5 <= z4;
      for (int b = 0; b < NUM_BANKS; b++) begin
        rg1[b] <= rg_next[b];
        wb1[b] <= wb_next[b];
        w2[b]  <= 18'(rg1[b]) * 18'(wb1[b]);
        for (int ch = 0; ch < NUM_CH; ch++) begin
          d2[b][ch] <= rdata[b][ch];
          // zero weight corners may sit on unwritten entries
          p3[b][ch] <= (w2[b] == '0) ? '0 : 26'(w2[b]) * 26'(d2[b][ch]);
        end
      end
      for (int ch = 0; ch < NUM_CH; ch++) begin
        s4[ch] <= 26'(p3[0][ch] + p3[1][ch] + p3[2][ch] + p3[3][ch]
                      + p3[4][ch] + p3[5][ch] + p3[6][ch] + p3[7][ch]);
        s5[ch] <= s4[ch];
        q5[ch] <= 8'((40'(s4[ch]) * 40'(RECIP_51C)) >> 32);
      end
    end
  end

  // quotient correction and output register
  always_ff @(posedge clk) begin
    logic [25:0] r;
    logic [7:0]  q [NUM_CH];
    for (int ch = 0; ch < NUM_CH; ch++) begin
      r = 26'(s5[ch]) - 26'(q5[ch]) * 26'(DIV_TOTAL);
      q[ch] = (r >= 26'(DIV_TOTAL)) ? q5[ch] + 8'd1 : q5[ch];
      if (z5) begin
        q[ch] = '0;
      end
    end
    if (adv) begin
      out_data.red_out   <= q[0];
      out_data.green_out <= q[1];
      out_data.blue_out  <= q[2];
    end
  end

endmodule

[rtl/lut3d_trilinear_interp_unit.sv]
// top level: 6x6x6 3d lut with trilinear interpolation, one pixel per clock while the output is not stalled
// input transfer passes front register, queue slot, ram read, weight, product, sum, quotient and output registers
// throughput one item per cycle while the output is not stalled: eight parity banks serve all eight corners at once
// reset clears control state only; grid store contents are undefined until written
// depends on l3dti_pkg, l3dti_front, l3dti_queue, l3dti_back, l3dti_ram
`timescale 1ns / 1ps
module lut3d_trilinear_interp_unit import l3dti_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // front to queue
  logic    push;
  q_item_t push_item;
  logic    q_full;

  // queue to back
  logic    pop;
  logic    head_valid;
  q_item_t head;

  // front decodes the transfer: cell index and remainder per channel, or
  // node coordinates for a grid write
  l3dti_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  // short queue lets front keep taking transfers while output is stalled
  l3dti_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // back performs writes in order with reads, so a pixel sees earlier writes
  l3dti_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
